[rtl/core/sipo_pkg.sv]
// Package: payload types, opcodes, register indexes and reset values of the shift register driver.
`default_nettype none

package sipo_pkg;

  // Default sizes handed to the top level
  localparam int unsigned WORD_BITS_DEF       = 32;
  localparam int unsigned TICK_COUNT_BITS_DEF = 24;

  // Fixed field widths
  localparam int unsigned OPCODE_W   = 2;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 3;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SHIFT = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_LATCH = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_RISING_EDGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_ACTIVE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HALF_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SETUP_TICKS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_PULSE_TICKS = 3'd4;

  // Register reset values
  localparam logic           RST_CLOCK_RISING_EDGE = 1'b1;
  localparam logic           RST_LATCH_ACTIVE_HIGH = 1'b1;
  localparam int unsigned    RST_TICKS             = 1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [WORD_W-1:0]   word_value;
    logic [COUNT_W-1:0]  bit_count;
  } in_t;

  typedef struct packed {
    logic clock_level;
    logic data_level;
    logic latch_level;
    logic busy_res;
    logic rejected;
  } out_t;

endpackage

`default_nettype wire

[rtl/core/sipo_shift_register_loader.sv]
// Top level: serial driver for the clock, data and latch lines of a shift register.
`default_nettype none

// Each input beat is one timing tick and may start a command: shift sends the low
// bit_count bits of word_value MSB first (setup, clock idle half, clock active half per
// bit); latch pulses the latch line. Each phase lasts max(N,1) ticks from the matching
// tick register. A command that arrives while a sequence runs is dropped and flagged
// with rejected. One input beat is taken every clock cycle: the phase sequencer updates
// in a single pass from its state registers and the beat, and the result beat lands in
// an output register. The input stalls only while that register holds a result that the
// receiver is stalling. Configuration writes take effect at the next edge and should be
// made while no beat is in flight; a polarity change leaves the lines at their present
// levels until a later phase drives them.
module sipo_shift_register_loader #(
  parameter int unsigned WORD_BITS       = sipo_pkg::WORD_BITS_DEF,
  parameter int unsigned TICK_COUNT_BITS = sipo_pkg::TICK_COUNT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire sipo_pkg::in_t                    in_data,
  // result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output sipo_pkg::out_t                        out_data,
  // configuration port
  input  wire logic                             cfg_we,
  input  wire logic [sipo_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [sipo_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned BL_W   = $clog2(WORD_BITS + 1);
  localparam int unsigned IDX_W  = $clog2(WORD_BITS);
  localparam int unsigned CNT7_W = 7;  // holds any bit count and WORD_BITS up to 64
  localparam int unsigned WEXT_W = (WORD_BITS > sipo_pkg::WORD_W) ? WORD_BITS
                                                                 : sipo_pkg::WORD_W;
  localparam int unsigned TEXT_W = (TICK_COUNT_BITS > sipo_pkg::CFG_DATA_W)
                                   ? TICK_COUNT_BITS : sipo_pkg::CFG_DATA_W;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETUP,
    PH_CLK_IDLE,
    PH_CLK_ACTIVE,
    PH_LATCH
  } phase_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                       clk_rising_r;
  logic                       latch_high_r;
  logic [TICK_COUNT_BITS-1:0] half_ticks_r;
  logic [TICK_COUNT_BITS-1:0] setup_ticks_r;
  logic [TICK_COUNT_BITS-1:0] pulse_ticks_r;
  logic [TEXT_W-1:0]          cfg_wdata_ext;
  logic [TICK_COUNT_BITS-1:0] cfg_ticks;

  assign cfg_wdata_ext = TEXT_W'(cfg_wdata);
  assign cfg_ticks     = cfg_wdata_ext[TICK_COUNT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_rising_r  <= sipo_pkg::RST_CLOCK_RISING_EDGE;
      latch_high_r  <= sipo_pkg::RST_LATCH_ACTIVE_HIGH;
      half_ticks_r  <= TICK_COUNT_BITS'(sipo_pkg::RST_TICKS);
      setup_ticks_r <= TICK_COUNT_BITS'(sipo_pkg::RST_TICKS);
      pulse_ticks_r <= TICK_COUNT_BITS'(sipo_pkg::RST_TICKS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        sipo_pkg::REG_CLOCK_RISING_EDGE: clk_rising_r  <= cfg_wdata[0];
        sipo_pkg::REG_LATCH_ACTIVE_HIGH: latch_high_r  <= cfg_wdata[0];
        sipo_pkg::REG_CLOCK_HALF_TICKS:  half_ticks_r  <= cfg_ticks;
        sipo_pkg::REG_DATA_SETUP_TICKS:  setup_ticks_r <= cfg_ticks;
        sipo_pkg::REG_LATCH_PULSE_TICKS: pulse_ticks_r <= cfg_ticks;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Phase lengths: a zero register still gives one tick
  logic [TICK_COUNT_BITS-1:0] dur_half;
  logic [TICK_COUNT_BITS-1:0] dur_setup;
  logic [TICK_COUNT_BITS-1:0] dur_pulse;

  assign dur_half  = (half_ticks_r  == '0) ? TICK_COUNT_BITS'(1) : half_ticks_r;
  assign dur_setup = (setup_ticks_r == '0) ? TICK_COUNT_BITS'(1) : setup_ticks_r;
  assign dur_pulse = (pulse_ticks_r == '0) ? TICK_COUNT_BITS'(1) : pulse_ticks_r;

  // ---------------------------------------------------------------------------
  // Handshake: take a beat whenever the output register is free or draining
  // ---------------------------------------------------------------------------
  logic out_valid_r;
  logic in_accept;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  phase_t                     phase_r, phase_nxt;
  logic [TICK_COUNT_BITS-1:0] left_r, left_nxt;
  logic [WORD_BITS-1:0]       word_r, word_nxt;
  logic [BL_W-1:0]            bits_r, bits_nxt;
  logic                       clk_out_r, clk_out_nxt;
  logic                       data_out_r, data_out_nxt;
  logic                       latch_out_r, latch_out_nxt;
  sipo_pkg::out_t             out_data_r, out_data_nxt;

  // Helpers for the single pass
  logic [TICK_COUNT_BITS-1:0] left_dec;
  logic [BL_W-1:0]            bits_dec;
  logic [BL_W-1:0]            bits_pos;
  logic [CNT7_W-1:0]          count_ext;
  logic [BL_W-1:0]            count_sat;
  logic [BL_W-1:0]            count_pos;
  logic [WEXT_W-1:0]          in_word_ext;
  logic [WORD_BITS-1:0]       in_word;
  logic                       is_cmd;
  logic                       rejected;

  assign left_dec    = left_r - TICK_COUNT_BITS'(1);
  assign bits_dec    = (bits_r != '0) ? bits_r - BL_W'(1) : bits_r;
  assign bits_pos    = bits_dec - BL_W'(1);
  assign count_ext   = CNT7_W'(in_data.bit_count);
  assign count_sat   = (count_ext > CNT7_W'(WORD_BITS)) ? BL_W'(WORD_BITS)
                                                        : BL_W'(count_ext);
  assign count_pos   = count_sat - BL_W'(1);
  assign in_word_ext = WEXT_W'(in_data.word_value);
  assign in_word     = in_word_ext[WORD_BITS-1:0];
  assign is_cmd      = (in_data.opcode == sipo_pkg::OP_SHIFT) ||
                       (in_data.opcode == sipo_pkg::OP_LATCH);

  always_comb begin
    phase_nxt     = phase_r;
    left_nxt      = left_r;
    word_nxt      = word_r;
    bits_nxt      = bits_r;
    clk_out_nxt   = clk_out_r;
    data_out_nxt  = data_out_r;
    latch_out_nxt = latch_out_r;
    rejected      = 1'b0;

    // Advance the running phase by one tick
    if (phase_r != PH_IDLE) begin
      left_nxt = left_dec;
      if (left_dec == '0) begin
        unique case (phase_r)
          PH_SETUP: begin
            clk_out_nxt = !clk_rising_r;
            phase_nxt   = PH_CLK_IDLE;
            left_nxt    = dur_half;
          end
          PH_CLK_IDLE: begin
            clk_out_nxt = clk_rising_r;
            phase_nxt   = PH_CLK_ACTIVE;
            left_nxt    = dur_half;
          end
          PH_CLK_ACTIVE: begin
            bits_nxt = bits_dec;
            if (bits_dec != '0) begin
              data_out_nxt = word_r[bits_pos[IDX_W-1:0]];
              phase_nxt    = PH_SETUP;
              left_nxt     = dur_setup;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
          PH_LATCH: begin
            latch_out_nxt = !latch_high_r;
            phase_nxt     = PH_IDLE;
          end
          default: begin
            phase_nxt = PH_IDLE;
            left_nxt  = '0;
          end
        endcase
      end
    end

    // Start a command if the sequencer is free after this tick's advance
    if (is_cmd) begin
      if (phase_nxt != PH_IDLE) begin
        rejected = 1'b1;
      end else if (in_data.opcode == sipo_pkg::OP_SHIFT) begin
        if (count_sat != '0) begin
          word_nxt     = in_word;
          bits_nxt     = count_sat;
          data_out_nxt = in_word[count_pos[IDX_W-1:0]];
          phase_nxt    = PH_SETUP;
          left_nxt     = dur_setup;
        end
      end else begin
        latch_out_nxt = latch_high_r;
        phase_nxt     = PH_LATCH;
        left_nxt      = dur_pulse;
      end
    end

    out_data_nxt.clock_level = clk_out_nxt;
    out_data_nxt.data_level  = data_out_nxt;
    out_data_nxt.latch_level = latch_out_nxt;
    out_data_nxt.busy_res    = (phase_nxt != PH_IDLE);
    out_data_nxt.rejected    = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      left_r      <= '0;
      word_r      <= '0;
      bits_r      <= '0;
      clk_out_r   <= 1'b0;
      data_out_r  <= 1'b0;
      latch_out_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_r     <= phase_nxt;
        left_r      <= left_nxt;
        word_r      <= word_nxt;
        bits_r      <= bits_nxt;
        clk_out_r   <= clk_out_nxt;
        data_out_r  <= data_out_nxt;
        latch_out_r <= latch_out_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: hold while stalled, load with each accepted beat
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[verif/tb_sipo_shift_register_loader.sv]
// Self-checking testbench for the shift register serial driver: directed table, random ticks.
`timescale 1ns / 1ps

module tb_sipo_shift_register_loader;

  localparam int unsigned OPCODE_W   = sipo_pkg::OPCODE_W;
  localparam int unsigned WORD_W     = sipo_pkg::WORD_W;
  localparam int unsigned COUNT_W    = sipo_pkg::COUNT_W;
  localparam int unsigned CFG_DATA_W = sipo_pkg::CFG_DATA_W;
  localparam int unsigned CFG_IDX_W  = sipo_pkg::CFG_IDX_W;

  localparam int unsigned LINE_BITS    = sipo_pkg::WORD_BITS_DEF;
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned PHASE_BEATS  = 280;
  localparam int unsigned MAX_REPORTS  = 10;

  // Opcode 3 is not a command; the block must treat it as a plain tick.
  localparam logic [OPCODE_W-1:0]   OP_SPARE = 2'd3;
  localparam logic [CFG_DATA_W-1:0] TICK_MAX = '1;

  // Line levels as {clock, data, latch, busy, rejected}.
  localparam logic [4:0] LINES_QUIET = 5'b00000;
  localparam logic [4:0] LINES_LATCH = 5'b00110;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_SETUP,
    SEQ_CLK_IDLE,
    SEQ_CLK_ACTIVE,
    SEQ_LATCH
  } seq_phase_t;

  typedef struct {
    sipo_pkg::in_t  beat;
    logic           typed;
    sipo_pkg::out_t want;
  } dir_row_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  sipo_pkg::in_t         in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  sipo_pkg::out_t        out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Typed-in expectation riding along with a directed beat.
  logic           row_typed = 1'b0;
  sipo_pkg::out_t row_want  = '0;

  // Predictor copy of the registers and the sequencer state.
  logic                  cf_rise;
  logic                  cf_latch_hi;
  logic [CFG_DATA_W-1:0] cf_half;
  logic [CFG_DATA_W-1:0] cf_setup;
  logic [CFG_DATA_W-1:0] cf_pulse;
  seq_phase_t            seq_phase;
  logic [CFG_DATA_W-1:0] seq_left;
  logic [WORD_W-1:0]     seq_word;
  logic [COUNT_W-1:0]    seq_bits;
  logic                  pin_clk;
  logic                  pin_dat;
  logic                  pin_lat;

  sipo_pkg::out_t line_levels_due[$];
  dir_row_t       dir_rows[$];
  int             errors      = 0;
  int             cycle_count = 0;
  int             source_mode = 0;
  int             sink_mode   = 0;
  int             squeeze_len = 0;

  sipo_shift_register_loader dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A zero tick register still holds the phase for one tick.
  function automatic logic [CFG_DATA_W-1:0] hold_ticks(input logic [CFG_DATA_W-1:0] n);
    return (n == '0) ? CFG_DATA_W'(1) : n;
  endfunction

  // Put the next bit (MSB of what is left) on the data line and start its setup.
  function automatic void present_bit();
    pin_dat   = seq_word[seq_bits - 1];
    seq_phase = SEQ_SETUP;
    seq_left  = hold_ticks(cf_setup);
  endfunction

  // Count down the running phase; on expiry move to the next one.
  function automatic void step_phase();
    seq_left = seq_left - 1'b1;
    if (seq_left == '0) begin
      case (seq_phase)
        SEQ_SETUP: begin
          pin_clk   = !cf_rise;
          seq_phase = SEQ_CLK_IDLE;
          seq_left  = hold_ticks(cf_half);
        end
        SEQ_CLK_IDLE: begin
          pin_clk   = cf_rise;
          seq_phase = SEQ_CLK_ACTIVE;
          seq_left  = hold_ticks(cf_half);
        end
        SEQ_CLK_ACTIVE: begin
          if (seq_bits != '0) seq_bits = seq_bits - 1'b1;
          if (seq_bits != '0) present_bit();
          else seq_phase = SEQ_IDLE;
        end
        SEQ_LATCH: begin
          pin_lat   = !cf_latch_hi;
          seq_phase = SEQ_IDLE;
        end
        default: begin
          seq_phase = SEQ_IDLE;
          seq_left  = '0;
        end
      endcase
    end
  endfunction

  // Advance one tick with this beat and return the line levels it leaves behind.
  function automatic sipo_pkg::out_t next_line_levels(input sipo_pkg::in_t beat);
    sipo_pkg::out_t     lv;
    logic [COUNT_W-1:0] cnt;
    logic               refused;
    refused = 1'b0;
    cnt     = beat.bit_count;
    if (seq_phase != SEQ_IDLE) step_phase();
    if (beat.opcode == sipo_pkg::OP_SHIFT || beat.opcode == sipo_pkg::OP_LATCH) begin
      if (seq_phase != SEQ_IDLE) begin
        refused = 1'b1;
      end else if (beat.opcode == sipo_pkg::OP_SHIFT) begin
        if (cnt > LINE_BITS) cnt = COUNT_W'(LINE_BITS);
        if (cnt != '0) begin
          seq_word = beat.word_value;
          seq_bits = cnt;
          present_bit();
        end
      end else begin
        pin_lat   = cf_latch_hi;
        seq_phase = SEQ_LATCH;
        seq_left  = hold_ticks(cf_pulse);
      end
    end
    lv.clock_level = pin_clk;
    lv.data_level  = pin_dat;
    lv.latch_level = pin_lat;
    lv.busy_res    = (seq_phase != SEQ_IDLE);
    lv.rejected    = refused;
    return lv;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mode 0: back to back; mode 1: always lazy; mode 2: mostly back to back.
  function automatic int pick_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 18);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
    endcase
  endfunction

  function automatic void add_row(input logic [OPCODE_W-1:0] op, input logic [WORD_W-1:0] word,
                                  input logic [COUNT_W-1:0] cnt, input logic typed,
                                  input logic [4:0] want);
    dir_row_t r;
    r.beat  = {op, word, cnt};
    r.typed = typed;
    r.want  = want;
    dir_rows.push_back(r);
  endfunction

  function automatic sipo_pkg::in_t tick_beat();
    return {sipo_pkg::OP_TICK, WORD_W'($urandom()), COUNT_W'($urandom_range(0, 63))};
  endfunction

  // Idle: mostly start commands. Busy: mostly plain ticks, a few commands to be rejected.
  function automatic sipo_pkg::in_t random_beat();
    sipo_pkg::in_t       b;
    int                  r;
    logic [COUNT_W-1:0]  cnt;
    r   = $urandom_range(0, 99);
    cnt = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(0, 63))
                                      : COUNT_W'($urandom_range(1, 8));
    b   = {sipo_pkg::OP_TICK, WORD_W'($urandom()), cnt};
    if (seq_phase == SEQ_IDLE) begin
      if (r < 50)      b.opcode = sipo_pkg::OP_SHIFT;
      else if (r < 78) b.opcode = sipo_pkg::OP_LATCH;
      else if (r < 92) b.opcode = sipo_pkg::OP_TICK;
      else             b.opcode = OP_SPARE;
    end else begin
      if (r < 85)      b.opcode = sipo_pkg::OP_TICK;
      else if (r < 92) b.opcode = sipo_pkg::OP_SHIFT;
      else if (r < 97) b.opcode = sipo_pkg::OP_LATCH;
      else             b.opcode = OP_SPARE;
    end
    return b;
  endfunction

  // Offer one beat and hold it until the block takes it. Valid stays high on return;
  // the caller either offers the next beat or drops valid at this same falling edge.
  task automatic offer(input sipo_pkg::in_t beat, input logic typed = 1'b0,
                       input sipo_pkg::out_t want = '0);
    int gap;
    gap = pick_gap(source_mode);
    if ($urandom_range(0, 49) == 0) source_mode = $urandom_range(0, 2);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_data   <= beat;
    row_typed <= typed;
    row_want  <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Run plain ticks until the sequencer is idle, then drain every result in flight.
  task automatic settle();
    while (seq_phase != SEQ_IDLE) offer(tick_beat());
    in_valid <= 1'b0;
    while (line_levels_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    case (idx)
      sipo_pkg::REG_CLOCK_RISING_EDGE: cf_rise     = val[0];
      sipo_pkg::REG_LATCH_ACTIVE_HIGH: cf_latch_hi = val[0];
      sipo_pkg::REG_CLOCK_HALF_TICKS:  cf_half     = val;
      sipo_pkg::REG_DATA_SETUP_TICKS:  cf_setup    = val;
      sipo_pkg::REG_LATCH_PULSE_TICKS: cf_pulse    = val;
      default: ;
    endcase
  endtask

  // Write every register with the block quiet; line levels carry over a polarity change.
  task automatic set_config(input logic rise, input logic latch_hi,
                            input logic [CFG_DATA_W-1:0] half,
                            input logic [CFG_DATA_W-1:0] setup,
                            input logic [CFG_DATA_W-1:0] pulse);
    settle();
    write_reg(sipo_pkg::REG_CLOCK_RISING_EDGE, CFG_DATA_W'(rise));
    write_reg(sipo_pkg::REG_LATCH_ACTIVE_HIGH, CFG_DATA_W'(latch_hi));
    write_reg(sipo_pkg::REG_CLOCK_HALF_TICKS, half);
    write_reg(sipo_pkg::REG_DATA_SETUP_TICKS, setup);
    write_reg(sipo_pkg::REG_LATCH_PULSE_TICKS, pulse);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stall per beat, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      if (squeeze_len > 0) begin
        hold        = squeeze_len;
        squeeze_len = 0;
      end else begin
        hold = pick_gap(sink_mode);
      end
      if ($urandom_range(0, 49) == 0) sink_mode = $urandom_range(0, 2);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input beat, check every accepted result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sipo_pkg::out_t guess;
    sipo_pkg::out_t want;
    sipo_pkg::out_t got;
    cycle_count = cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, line_levels_due.size());
      $display("sipo_shift_register_loader regression: fail");
      $finish;
    end else if (rst_n) begin
      // Input side first, so a result that appears with its own input beat would still find its expectation.
      if (in_valid && !in_stall) begin
        guess = next_line_levels(in_data);
        line_levels_due.push_back(row_typed ? row_want : guess);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (line_levels_due.size() == 0) begin
          errors = errors + 1;
          if (errors <= MAX_REPORTS)
            $display({"cycle %0d: result with nothing expected: ",
                      "clk=%b dat=%b lat=%b busy=%b rej=%b"},
                     cycle_count, got.clock_level, got.data_level, got.latch_level,
                     got.busy_res, got.rejected);
        end else begin
          want = line_levels_due.pop_front();
          if (got.clock_level !== want.clock_level || got.data_level !== want.data_level ||
              got.latch_level !== want.latch_level || got.busy_res !== want.busy_res ||
              got.rejected !== want.rejected) begin
            errors = errors + 1;
            if (errors <= MAX_REPORTS)
              $display({"cycle %0d: mismatch, ",
                        "expected clk=%b dat=%b lat=%b busy=%b rej=%b, ",
                        "got clk=%b dat=%b lat=%b busy=%b rej=%b"},
                       cycle_count, want.clock_level, want.data_level, want.latch_level,
                       want.busy_res, want.rejected, got.clock_level, got.data_level,
                       got.latch_level, got.busy_res, got.rejected);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Reset state of the registers and of the lines (reset polarity).
    cf_rise     = sipo_pkg::RST_CLOCK_RISING_EDGE;
    cf_latch_hi = sipo_pkg::RST_LATCH_ACTIVE_HIGH;
    cf_half     = CFG_DATA_W'(sipo_pkg::RST_TICKS);
    cf_setup    = CFG_DATA_W'(sipo_pkg::RST_TICKS);
    cf_pulse    = CFG_DATA_W'(sipo_pkg::RST_TICKS);
    seq_phase   = SEQ_IDLE;
    seq_left    = '0;
    seq_word    = '0;
    seq_bits    = '0;
    pin_clk     = !sipo_pkg::RST_CLOCK_RISING_EDGE;
    pin_dat     = 1'b0;
    pin_lat     = !sipo_pkg::RST_LATCH_ACTIVE_HIGH;

    // Directed table, run with reset registers: every phase lasts one tick.
    add_row(sipo_pkg::OP_TICK,  32'h0000_0000, 6'd0,  1'b1, LINES_QUIET);
    add_row(OP_SPARE,           32'hFFFF_FFFF, 6'd63, 1'b1, LINES_QUIET); // spare opcode
    add_row(sipo_pkg::OP_SHIFT, 32'hFFFF_FFFF, 6'd0,  1'b1, LINES_QUIET); // zero-bit shift
    add_row(sipo_pkg::OP_LATCH, 32'h0000_0000, 6'd0,  1'b1, LINES_LATCH);
    add_row(sipo_pkg::OP_SHIFT, 32'h0000_0002, 6'd2,  1'b0, LINES_QUIET); // as pulse ends
    add_row(sipo_pkg::OP_LATCH, 32'h0000_0000, 6'd0,  1'b0, LINES_QUIET); // busy: rejected
    add_row(sipo_pkg::OP_SHIFT, 32'hFFFF_FFFF, 6'd32, 1'b0, LINES_QUIET); // busy: rejected
    add_row(OP_SPARE,           32'h0000_0000, 6'd0,  1'b0, LINES_QUIET); // not rejected
    add_row(sipo_pkg::OP_TICK,  32'hFFFF_FFFF, 6'd63, 1'b0, LINES_QUIET);
    add_row(sipo_pkg::OP_TICK,  32'h0000_0000, 6'd0,  1'b0, LINES_QUIET);
    add_row(sipo_pkg::OP_LATCH, 32'h0000_0000, 6'd0,  1'b0, LINES_QUIET); // as shift ends
    add_row(sipo_pkg::OP_TICK,  32'h0000_0000, 6'd0,  1'b0, LINES_QUIET);
    add_row(sipo_pkg::OP_SHIFT, 32'h0000_0001, 6'd1,  1'b0, LINES_QUIET);
    add_row(sipo_pkg::OP_TICK,  32'h0000_0000, 6'd0,  1'b0, LINES_QUIET);
    add_row(sipo_pkg::OP_TICK,  32'h0000_0000, 6'd0,  1'b0, LINES_QUIET);
    add_row(sipo_pkg::OP_SHIFT, 32'h8000_0000, 6'd40, 1'b0, LINES_QUIET); // count saturates
    add_row(sipo_pkg::OP_LATCH, 32'h0000_0000, 6'd0,  1'b0, LINES_QUIET); // busy: rejected

    // Hold reset, then release it at a falling edge.
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) offer(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);

    // Random phases: zero ticks, inverted polarities, mixed timing, then back to reset values.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(1'b1, 1'b1, '0, '0, '0);
        1: set_config(1'b0, 1'b0, 24'd2, 24'd1, 24'd3);
        2: set_config(1'b0, 1'b1, CFG_DATA_W'($urandom_range(0, 4)),
                      CFG_DATA_W'($urandom_range(0, 4)), CFG_DATA_W'($urandom_range(0, 6)));
        3: set_config(1'b1, 1'b0, CFG_DATA_W'($urandom_range(0, 4)),
                      CFG_DATA_W'($urandom_range(0, 4)), CFG_DATA_W'($urandom_range(0, 6)));
        4: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      CFG_DATA_W'($urandom_range(0, 6)), CFG_DATA_W'($urandom_range(0, 6)),
                      CFG_DATA_W'($urandom_range(0, 9)));
        default: set_config(sipo_pkg::RST_CLOCK_RISING_EDGE,
                            sipo_pkg::RST_LATCH_ACTIVE_HIGH,
                            CFG_DATA_W'(sipo_pkg::RST_TICKS),
                            CFG_DATA_W'(sipo_pkg::RST_TICKS),
                            CFG_DATA_W'(sipo_pkg::RST_TICKS));
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // Hold off the sink for a long stretch while beats keep coming back to back.
        if (p == 2 && n == 100) begin
          squeeze_len = 150;
          source_mode = 0;
        end
        offer(random_beat());
      end
    end

    // Largest tick counts last: the first command never finishes, the rest get rejected.
    set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), TICK_MAX, TICK_MAX, TICK_MAX);
    offer({sipo_pkg::OP_SHIFT, WORD_W'($urandom()), COUNT_W'(LINE_BITS)});
    for (int n = 0; n < 40; n++) offer(random_beat());

    // Drop valid, wait for every expected result, then keep watching for strays.
    in_valid <= 1'b0;
    while (line_levels_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    if (errors == 0)
      $display("sipo_shift_register_loader regression: pass");
    else
      $display("sipo_shift_register_loader regression: fail");
    $finish;
  end

endmodule

[files.f]
rtl/core/sipo_pkg.sv
rtl/core/sipo_shift_register_loader.sv
verif/tb_sipo_shift_register_loader.sv
